@@ rtl/assert_macros.svh @@
// Assertion macros for the display writer; the nibble sequencer includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk while i_rst_n is high.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge of i_clk, during reset too.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/cln_pkg.sv @@
// Types, constants and command tables of the character display nibble writer.
`default_nettype none

package cln_pkg;

    // Field and state widths.
    localparam int unsigned NIB_W   = 4;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COL_W   = 6;
    localparam int unsigned LINE_W  = 2;
    localparam int unsigned STEP_W  = 5;

    // Defaults handed down from the top level.
    localparam int unsigned DEFAULT_LINE_CHARS  = 20;
    localparam int unsigned DEFAULT_QUEUE_DEPTH = 2;

    // Request codes; a queued job carries the same code as its kind.
    typedef enum logic [1:0] {
        REQ_CHAR  = 2'd0,
        REQ_LINE  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_INIT  = 2'd3
    } t_req;

    // DDRAM address commands of the four lines.
    localparam logic [BYTE_W-1:0] CMD_LINE1 = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_LINE2 = 8'hC0;
    localparam logic [BYTE_W-1:0] CMD_LINE3 = 8'h94;
    localparam logic [BYTE_W-1:0] CMD_LINE4 = 8'hD4;

    // Initialization commands.
    localparam logic [NIB_W-1:0]  NIB_WAKE     = 4'h3;
    localparam logic [NIB_W-1:0]  NIB_FOUR_BIT = 4'h2;
    localparam logic [BYTE_W-1:0] CMD_FUNC_SET = 8'h28;
    localparam logic [BYTE_W-1:0] CMD_CLEAR    = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_SHIFT    = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_ENTRY    = 8'h06;
    localparam logic [BYTE_W-1:0] CMD_DISP_ON  = 8'h0C;

    // Step numbers of the final nibble of each run.
    localparam logic [STEP_W-1:0] STEP_PAIR_LAST  = 5'd1;
    localparam logic [STEP_W-1:0] STEP_WRAP_LAST  = 5'd3;
    localparam logic [STEP_W-1:0] STEP_CLEAR_LAST = 5'd3;
    localparam logic [STEP_W-1:0] STEP_INIT_LAST  = 5'd17;
    // A clear run is the tail of the init run.
    localparam logic [STEP_W-1:0] CLEAR_BASE      = 5'd14;
    localparam logic [STEP_W-1:0] INIT_LEAD_STEPS = 5'd4;

    // One decoded job handed from the front to the back.
    typedef struct packed {
        t_req              kind;
        logic [BYTE_W-1:0] data;
        logic              wrap;
        logic [LINE_W-1:0] line;
    } t_job;

    // Address command of a line.
    function automatic logic [BYTE_W-1:0] line_addr(input logic [LINE_W-1:0] idx);
        logic [BYTE_W-1:0] cmd;
        case (idx)
            2'd0:    cmd = CMD_LINE1;
            2'd1:    cmd = CMD_LINE2;
            2'd2:    cmd = CMD_LINE3;
            default: cmd = CMD_LINE4;
        endcase
        return cmd;
    endfunction

    // Byte commands of the init run after the four lead nibbles.
    function automatic logic [BYTE_W-1:0] init_byte(input logic [2:0] k);
        logic [BYTE_W-1:0] cmd;
        case (k)
            3'd0:    cmd = CMD_FUNC_SET;
            3'd1:    cmd = CMD_CLEAR;
            3'd2:    cmd = CMD_SHIFT;
            3'd3:    cmd = CMD_ENTRY;
            3'd4:    cmd = CMD_DISP_ON;
            3'd5:    cmd = CMD_CLEAR;
            default: cmd = CMD_LINE1;
        endcase
        return cmd;
    endfunction

    // Nibble at a given step of the init run.
    function automatic logic [NIB_W-1:0] init_nibble(input logic [STEP_W-1:0] idx);
        logic [STEP_W-1:0] off;
        logic [BYTE_W-1:0] cmd;
        logic [NIB_W-1:0]  nib;
        off = idx - INIT_LEAD_STEPS;
        cmd = init_byte(off[3:1]);
        if (idx < INIT_LEAD_STEPS) begin
            nib = (idx == INIT_LEAD_STEPS - 5'd1) ? NIB_FOUR_BIT : NIB_WAKE;
        end else begin
            nib = off[0] ? cmd[3:0] : cmd[7:4];
        end
        return nib;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cln_stream_if.sv @@
// Valid/ready channel interfaces for requests and for bus nibbles.
`default_nettype none

interface cln_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface cln_nib_if;
    logic       valid;
    logic       ready;
    logic [3:0] nibble;
    logic       reg_select;
    logic       last;

    modport source (output valid, output nibble, output reg_select, output last, input ready);
    modport sink   (input valid, input nibble, input reg_select, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/cln_front.sv @@
// Request front end: decodes requests and tracks column and line.
`default_nettype none

module cln_front #(
    parameter int unsigned LINE_CHARS = cln_pkg::DEFAULT_LINE_CHARS
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    cln_req_if.sink           i_req,
    input  wire logic         i_full,
    output logic              o_push,
    output cln_pkg::t_job     o_job
);
    import cln_pkg::*;

    localparam logic [COL_W-1:0] LINE_LIMIT = COL_W'(LINE_CHARS);

    logic [COL_W-1:0]  r_column, n_column;
    logic [LINE_W-1:0] r_line, n_line;
    logic [COL_W-1:0]  col_inc;
    logic              wrap;
    t_req              req;

    // A request is taken whenever the job queue has room.
    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    assign req     = t_req'(i_req.req_type);
    assign col_inc = r_column + COL_W'(1);
    assign wrap    = (col_inc >= LINE_LIMIT);

    // Decode the request into a job and the position after it.
    always_comb begin
        n_column   = r_column;
        n_line     = r_line;
        o_job.kind = req;
        o_job.data = i_req.value;
        o_job.wrap = 1'b0;
        o_job.line = '0;
        unique case (req)
            REQ_CHAR: begin
                o_job.wrap = wrap;
                o_job.line = r_line + LINE_W'(1);
                if (wrap) begin
                    n_column = '0;
                    n_line   = r_line + LINE_W'(1);
                end else begin
                    n_column = col_inc;
                end
            end
            REQ_LINE: begin
                o_job.line = i_req.value[LINE_W-1:0] - LINE_W'(1);
                n_column   = '0;
                n_line     = i_req.value[LINE_W-1:0] - LINE_W'(1);
            end
            REQ_CLEAR, REQ_INIT: begin
                n_column = '0;
                n_line   = '0;
            end
        endcase
    end

    // Position registers follow each accepted transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_line   <= '0;
        end else if (o_push) begin
            r_column <= n_column;
            r_line   <= n_line;
        end
    end

endmodule

`default_nettype wire

@@ rtl/cln_queue.sv @@
// Short job queue between the front end and the nibble sequencer.
`default_nettype none

module cln_queue #(
    parameter int unsigned DEPTH = cln_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire cln_pkg::t_job  i_job,
    output logic                o_full,
    output logic                o_valid,
    output cln_pkg::t_job       o_job,
    input  wire logic           i_pop
);
    import cln_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/cln_back.sv @@
// Nibble sequencer: walks the head job and drives the output register.
`default_nettype none

module cln_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire cln_pkg::t_job  i_job,
    output logic                o_pop,
    cln_nib_if.source           o_nib
);
    import cln_pkg::*;

    `include "assert_macros.svh"

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] last_step;
    logic [STEP_W-1:0] tab_idx;
    logic [BYTE_W-1:0] cur_byte;
    logic [NIB_W-1:0]  n_nibble;
    logic              n_rs;
    logic              is_last;
    logic              emit;
    logic              r_out_valid;
    logic [NIB_W-1:0]  r_nibble;
    logic              r_rs;
    logic              r_last;

    // A nibble leaves the sequencer whenever the output register is free.
    assign emit  = i_valid && (!r_out_valid || o_nib.ready);
    assign o_pop = emit && is_last;

    assign tab_idx = (i_job.kind == REQ_CLEAR) ? r_step + CLEAR_BASE : r_step;

    // Current nibble, register select and run length.
    always_comb begin
        cur_byte  = line_addr(i_job.line);
        n_rs      = 1'b0;
        last_step = STEP_PAIR_LAST;
        n_nibble  = r_step[0] ? cur_byte[3:0] : cur_byte[7:4];
        unique case (i_job.kind)
            REQ_CHAR: begin
                if (!r_step[1]) begin
                    cur_byte = i_job.data;
                    n_rs     = 1'b1;
                end
                n_nibble  = r_step[0] ? cur_byte[3:0] : cur_byte[7:4];
                last_step = i_job.wrap ? STEP_WRAP_LAST : STEP_PAIR_LAST;
            end
            REQ_LINE: begin
                last_step = STEP_PAIR_LAST;
            end
            REQ_CLEAR: begin
                n_nibble  = init_nibble(tab_idx);
                last_step = STEP_CLEAR_LAST;
            end
            REQ_INIT: begin
                n_nibble  = init_nibble(tab_idx);
                last_step = STEP_INIT_LAST;
            end
        endcase
    end

    assign is_last = (r_step == last_step);

    // Step counter within the head job.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (emit) begin
            r_step <= is_last ? '0 : r_step + STEP_W'(1);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_nib.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_nibble <= n_nibble;
            r_rs     <= n_rs;
            r_last   <= is_last;
        end
    end

    assign o_nib.valid      = r_out_valid;
    assign o_nib.nibble     = r_nibble;
    assign o_nib.reg_select = r_rs;
    assign o_nib.last       = r_last;

    // The step never runs past the longest run.
    `ASSERT_CLK(a_step_range, r_step <= STEP_INIT_LAST, "step counter out of range")
    // Data register writes come only from characters.
    `ASSERT_CLK(a_rs_char, (emit && n_rs) |-> (i_job.kind == REQ_CHAR), "stray data nibble")
    // The step restarts after the final nibble of a run.
    `ASSERT_CLK(a_step_restart, o_pop |=> (r_step == '0), "step did not restart after a run")

endmodule

`default_nettype wire

@@ rtl/char_lcd_nibble_writer.sv @@
// Top level of the character display nibble writer.
// Usage:
//   i_req carries one request per transfer: req_type selects show character,
//   go to line, clear or initialize, and value holds the character code or
//   the line number. o_nib carries one display bus write per transfer: four
//   data bits, the register select bit and a flag on the final nibble of a run.
//   A character gives 2 nibbles, or 4 when the line wraps; go to line gives 2,
//   clear 4, initialize 18.
// Flow:
//   The first nibble of a request is registered in the job queue and then in
//   the output register of the sequencer. The sequencer puts out one nibble
//   per cycle while o_nib.ready is high, through its single output slot. A
//   small job queue lets requests be taken while an earlier run is still
//   going out.
// Reset:
//   Column and line return to the start of line one; queue and output empty.
// Stalls:
//   A low o_nib.ready holds the current nibble; the queue fills and then
//   i_req.ready drops until room frees up.
`default_nettype none

module char_lcd_nibble_writer #(
    parameter int unsigned LINE_CHARS  = cln_pkg::DEFAULT_LINE_CHARS,
    parameter int unsigned QUEUE_DEPTH = cln_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cln_req_if.sink    i_req,
    cln_nib_if.source  o_nib
);
    import cln_pkg::*;

    logic push, pop, full, head_valid;
    t_job push_job, head_job;

    // Request decode and position tracking.
    cln_front #(
        .LINE_CHARS (LINE_CHARS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    // Job queue.
    cln_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .o_valid (head_valid),
        .o_job   (head_job),
        .i_pop   (pop)
    );

    // Nibble sequencing and output register.
    cln_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_nib   (o_nib)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench of the character display nibble writer.
`default_nettype none

module testbench;
    import cln_pkg::*;

    localparam int unsigned LINE_LEN    = DEFAULT_LINE_CHARS;
    localparam int          HOLD_CYCLES = 80;
    localparam int          STALL_LIMIT = 1000;
    localparam int          TAIL_CYCLES = 24;
    localparam int          SHOW_LIMIT  = 10;

    // One request waiting to be offered, with the traffic shaping that goes with it.
    typedef struct {
        t_req              kind;
        logic [BYTE_W-1:0] value;
        bit                wait_drain;
        bit                start_hold;
        int                src_pct;
        int                snk_pct;
    } t_req_item;

    // One bus write the block should put out.
    typedef struct {
        logic [NIB_W-1:0] nibble;
        logic             reg_select;
        logic             last;
    } t_bus_write;

    logic i_clk;
    logic i_rst_n;

    cln_req_if req_bus ();
    cln_nib_if nib_bus ();

    char_lcd_nibble_writer #(
        .LINE_CHARS (LINE_LEN)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_nib   (nib_bus)
    );

    t_req_item  pending_reqs[$];
    t_bus_write bus_expect[$];

    // Cursor as the display should see it.
    logic [COL_W-1:0]  cursor_col;
    logic [LINE_W-1:0] cursor_line;

    int  fail_count;
    int  reqs_sent;
    int  reqs_total;
    int  snk_pct;
    logic hold_kick;

    // Settings picked up by the next request added to the list.
    int  cur_src;
    int  cur_snk;
    bit  next_drain;
    bit  next_hold;

    // Clock generation.
    always #5 i_clk = ~i_clk;

    // Failure bookkeeping: only the first ten are shown.
    task automatic log_error(input string msg);
        fail_count++;
        if (fail_count <= SHOW_LIMIT) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    // Expected bus writes.
    task automatic put_nib(input logic [NIB_W-1:0] nib, input logic rs);
        t_bus_write w;
        w.nibble     = nib;
        w.reg_select = rs;
        w.last       = 1'b0;
        bus_expect.push_back(w);
    endtask

    task automatic put_byte(input logic [BYTE_W-1:0] b, input logic rs);
        put_nib(b[7:4], rs);
        put_nib(b[3:0], rs);
    endtask

    // Moves the cursor to the start of a line and sends its address command.
    task automatic goto_line(input logic [LINE_W-1:0] idx);
        logic [BYTE_W-1:0] addr;
        case (idx)
            2'd0:    addr = CMD_LINE1;
            2'd1:    addr = CMD_LINE2;
            2'd2:    addr = CMD_LINE3;
            default: addr = CMD_LINE4;
        endcase
        put_byte(addr, 1'b0);
        cursor_col  = '0;
        cursor_line = idx;
    endtask

    // Works out the bus writes caused by one accepted request.
    task automatic predict_bus_writes(input t_req kind, input logic [BYTE_W-1:0] val);
        logic [BYTE_W-1:0] line_num;
        line_num = val - 8'd1;
        case (kind)
            REQ_CHAR: begin
                put_byte(val, 1'b1);
                cursor_col = cursor_col + 1'b1;
                if (cursor_col >= LINE_LEN) begin
                    goto_line(cursor_line + 1'b1);
                end
            end
            REQ_LINE: begin
                goto_line(line_num[1:0]);
            end
            REQ_CLEAR: begin
                put_byte(CMD_CLEAR, 1'b0);
                goto_line(2'd0);
            end
            default: begin
                put_nib(NIB_WAKE, 1'b0);
                put_nib(NIB_WAKE, 1'b0);
                put_nib(NIB_WAKE, 1'b0);
                put_nib(NIB_FOUR_BIT, 1'b0);
                put_byte(CMD_FUNC_SET, 1'b0);
                put_byte(CMD_CLEAR, 1'b0);
                put_byte(CMD_SHIFT, 1'b0);
                put_byte(CMD_ENTRY, 1'b0);
                put_byte(CMD_DISP_ON, 1'b0);
                put_byte(CMD_CLEAR, 1'b0);
                goto_line(2'd0);
            end
        endcase
        bus_expect[bus_expect.size() - 1].last = 1'b1;
    endtask

    task automatic add_req(input t_req kind, input logic [BYTE_W-1:0] val);
        t_req_item it;
        it.kind       = kind;
        it.value      = val;
        it.wait_drain = next_drain;
        it.start_hold = next_hold;
        it.src_pct    = cur_src;
        it.snk_pct    = cur_snk;
        next_drain    = 1'b0;
        next_hold     = 1'b0;
        pending_reqs.push_back(it);
    endtask

    // Random traffic: runs of characters broken up by line moves, clears and inits.
    task automatic add_phase(input int n_items, input int src, input int snk,
                             input bit hold_once);
        int start;
        int burst;
        int pick;
        bit hold_left;
        start     = pending_reqs.size();
        hold_left = hold_once;
        cur_src   = src;
        cur_snk   = snk;
        // Each phase begins with the block drained.
        next_drain = 1'b1;
        while (pending_reqs.size() - start < n_items) begin
            burst = $urandom_range(45, 0);
            if ($urandom_range(3, 0) == 0) begin
                burst = $urandom_range(4, 0);
            end
            // Keep the phase close to its item count.
            if (burst > n_items - (pending_reqs.size() - start)) begin
                burst = n_items - (pending_reqs.size() - start);
            end
            repeat (burst) add_req(REQ_CHAR, 8'($urandom_range(255, 0)));
            pick = $urandom_range(9, 0);
            if (pick < 5) begin
                if ($urandom_range(1, 0) == 1) begin
                    add_req(REQ_LINE, 8'($urandom_range(4, 1)));
                end else begin
                    add_req(REQ_LINE, 8'($urandom_range(255, 0)));
                end
            end else if (pick < 8) begin
                add_req(REQ_CLEAR, 8'($urandom_range(255, 0)));
            end else if (pick < 9) begin
                add_req(REQ_INIT, 8'($urandom_range(255, 0)));
            end else begin
                add_req(t_req'($urandom_range(3, 0)), 8'($urandom_range(255, 0)));
            end
            // Long sink hold-off while the sender keeps offering.
            if (hold_left && pending_reqs.size() - start > 10) begin
                next_hold = 1'b1;
                hold_left = 1'b0;
            end
        end
    endtask

    // Request driver: offers the next pending item once the current one is taken.
    always @(posedge i_clk) begin : req_driver
        t_req_item nxt;
        logic      offer;
        logic      kick;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            hold_kick     <= 1'b0;
        end else begin
            kick = 1'b0;
            if (!req_bus.valid || req_bus.ready) begin
                if (req_bus.valid) begin
                    predict_bus_writes(t_req'(req_bus.req_type), req_bus.value);
                    reqs_sent++;
                end
                offer = 1'b0;
                if (pending_reqs.size() != 0) begin
                    if (!(pending_reqs[0].wait_drain && bus_expect.size() != 0) &&
                        $urandom_range(99, 0) >= pending_reqs[0].src_pct) begin
                        offer = 1'b1;
                    end
                end
                if (offer) begin
                    nxt = pending_reqs.pop_front();
                    req_bus.req_type <= nxt.kind;
                    req_bus.value    <= nxt.value;
                    snk_pct          <= nxt.snk_pct;
                    kick             = nxt.start_hold;
                end
                req_bus.valid <= offer;
            end
            hold_kick <= kick;
        end
    end

    // Bus monitor: checks every nibble transfer and drives the sink ready.
    always @(posedge i_clk) begin : nib_monitor
        t_bus_write want;
        int         hold_cnt;
        logic       rdy;
        if (!i_rst_n) begin
            nib_bus.ready <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (nib_bus.valid && nib_bus.ready) begin
                if (bus_expect.size() == 0) begin
                    log_error($sformatf("unexpected write nibble=%h rs=%b last=%b",
                              nib_bus.nibble, nib_bus.reg_select, nib_bus.last));
                end else begin
                    want = bus_expect.pop_front();
                    if (nib_bus.nibble !== want.nibble ||
                        nib_bus.reg_select !== want.reg_select ||
                        nib_bus.last !== want.last) begin
                        log_error($sformatf(
                            "expected nibble=%h rs=%b last=%b, got nibble=%h rs=%b last=%b",
                            want.nibble, want.reg_select, want.last,
                            nib_bus.nibble, nib_bus.reg_select, nib_bus.last));
                    end
                end
            end
            if (hold_kick) begin
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                rdy = 1'b0;
            end else begin
                rdy = ($urandom_range(99, 0) >= snk_pct);
            end
            nib_bus.ready <= rdy;
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin : watchdog
        int idle_cnt;
        if (!i_rst_n) begin
            idle_cnt = 0;
        end else if ((req_bus.valid && req_bus.ready) || (nib_bus.valid && nib_bus.ready)) begin
            idle_cnt = 0;
        end else begin
            idle_cnt++;
            if (idle_cnt >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Stimulus list, reset and end of run.
    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        req_bus.valid    = 1'b0;
        req_bus.req_type = REQ_CHAR;
        req_bus.value    = '0;
        nib_bus.ready    = 1'b0;
        hold_kick        = 1'b0;
        snk_pct          = 0;
        cursor_col       = '0;
        cursor_line      = '0;
        fail_count       = 0;
        reqs_sent        = 0;
        cur_src          = 0;
        cur_snk          = 0;
        next_drain       = 1'b0;
        next_hold        = 1'b0;

        // Directed part: every request kind, field extremes, odd line numbers.
        add_req(REQ_INIT, 8'h00);
        add_req(REQ_CHAR, 8'h00);
        add_req(REQ_CHAR, 8'hFF);
        add_req(REQ_CHAR, 8'hA5);
        add_req(REQ_CHAR, 8'h5A);
        add_req(REQ_LINE, 8'd1);
        add_req(REQ_LINE, 8'd2);
        add_req(REQ_CHAR, 8'h41);
        add_req(REQ_LINE, 8'd3);
        add_req(REQ_LINE, 8'd4);
        // Line numbers out of range fold back onto lines one to four.
        add_req(REQ_LINE, 8'd0);
        add_req(REQ_LINE, 8'd5);
        add_req(REQ_LINE, 8'd255);
        add_req(REQ_LINE, 8'd128);
        add_req(REQ_CHAR, 8'h7E);
        add_req(REQ_CLEAR, 8'hFF);
        add_req(REQ_CHAR, 8'h30);
        add_req(REQ_INIT, 8'hFF);
        add_req(REQ_CLEAR, 8'h00);
        add_req(REQ_LINE, 8'd4);
        add_req(REQ_CHAR, 8'h80);

        // Random part in four phases of differing idle rates; the first carries the long sink hold-off.
        add_phase(65, 0, 0, 1'b1);
        add_phase(65, 65, 0, 1'b0);
        add_phase(65, 0, 65, 1'b0);
        add_phase(65, 8, 8, 1'b0);
        reqs_total = pending_reqs.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (reqs_sent < reqs_total || bus_expect.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (bus_expect.size() != 0) begin
            log_error($sformatf("%0d bus writes never arrived", bus_expect.size()));
        end
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
